// ===== src/dpe_pkg.sv =====
// Package for the damped particle Euler integrator: item kinds, sequencer
// states, shared-unit opcodes, control structs and the saturation helper.
// Depends on nothing; every other file but dpe_checker refers to it by scope.
package dpe_pkg;

  // Fixed-point formats of the datapath.
  localparam int FRAC_BITS  = 16;
  localparam int DAMP_BITS  = 16;
  localparam int SQRT3_BITS = 30;
  localparam int AXES       = 3;

  // sqrt(3) with SQRT3_BITS fraction bits.
  localparam logic signed [31:0] SQRT3_FIXED = 32'sd1859775393;

  // Configuration register indexes.
  localparam logic [2:0] CFG_INV_MASS  = 3'd0;
  localparam logic [2:0] CFG_RADIUS    = 3'd1;
  localparam logic [2:0] CFG_DAMPING   = 3'd2;
  localparam logic [2:0] CFG_TIME_STEP = 3'd3;
  localparam logic [2:0] CFG_EXPLICIT  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [30:0] INV_MASS_RST  = 31'd65536;
  localparam logic [30:0] RADIUS_RST    = 31'd65536;
  localparam logic [16:0] DAMPING_RST   = 17'd65208;
  localparam logic [16:0] TIME_STEP_RST = 17'd1092;

  typedef enum logic [2:0] {
    KIND_FORCE   = 3'd0,
    KIND_STEP    = 3'd1,
    KIND_CLEAR   = 3'd2,
    KIND_SET_POS = 3'd3,
    KIND_SET_VEL = 3'd4,
    KIND_SET_ACC = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    OP_FORCE,   // acc += round(force * inverse_mass)
    OP_DAMP,    // tmp  = round(vel * damping)
    OP_ACCEL,   // nv   = tmp + round(acc * dt)
    OP_POS,     // pos += round(move_v * dt), vel = nv
    OP_HALF     // half = round(radius * sqrt3)
  } op_e;

  typedef enum logic [1:0] {
    SHIFT_FRAC,
    SHIFT_DAMP,
    SHIFT_SQRT3
  } shift_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } state_e;

  // Operands for the shared multiply unit.
  typedef struct packed {
    logic signed [32:0] a;
    logic signed [31:0] k;
    shift_e             shift;
  } mac_req_t;

  // Strobes and selects from the sequencer to the datapath.
  typedef struct packed {
    logic       ready;
    logic       mul_en;
    logic       add_en;
    logic       load_out;
    op_e        op;
    logic [1:0] axis;
  } ctrl_t;

  // Clamp a wide signed value into 32 bits signed.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/dpe_mac.sv =====
// Shared multiply, round and saturating accumulate unit.
// Depends on dpe_pkg for the operand struct, shift codes and sat32.
module dpe_mac (
  input  logic                  clk_i,
  input  logic                  mul_en_i,
  input  dpe_pkg::mac_req_t     req_i,
  input  logic signed [31:0]    addend_i,
  output logic signed [63:0]    rounded_o,
  output logic signed [31:0]    sum_o
);

  localparam logic signed [63:0] HALF_FRAC  = 64'sd1 <<< (dpe_pkg::FRAC_BITS - 1);
  localparam logic signed [63:0] HALF_DAMP  = 64'sd1 <<< (dpe_pkg::DAMP_BITS - 1);
  localparam logic signed [63:0] HALF_SQRT3 = 64'sd1 <<< (dpe_pkg::SQRT3_BITS - 1);

  logic signed [63:0] prod_d;
  logic signed [63:0] prod_q;
  dpe_pkg::shift_e    shift_q;
  logic signed [31:0] term;

  // Multiply cycle: exact product is registered.
  assign prod_d = req_i.a * req_i.k;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q  <= prod_d;
      shift_q <= req_i.shift;
    end
  end

  // Round half up: add half an LSB, then arithmetic shift (floor).
  always_comb begin
    unique case (shift_q)
      dpe_pkg::SHIFT_FRAC:  rounded_o = (prod_q + HALF_FRAC) >>> dpe_pkg::FRAC_BITS;
      dpe_pkg::SHIFT_DAMP:  rounded_o = (prod_q + HALF_DAMP) >>> dpe_pkg::DAMP_BITS;
      dpe_pkg::SHIFT_SQRT3: rounded_o = (prod_q + HALF_SQRT3) >>> dpe_pkg::SQRT3_BITS;
      default:              rounded_o = prod_q;
    endcase
  end

  // Saturate the rounded term, then add and saturate again.
  assign term  = dpe_pkg::sat32(rounded_o);
  assign sum_o = dpe_pkg::sat32(64'(term) + 64'(addend_i));

endmodule

// ===== src/dpe_ctrl.sv =====
// Sequencer that walks the shared unit through the micro-operations of an item.
// Depends on dpe_pkg for the state, opcode and control struct types.
module dpe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            is_step_i,
  input  logic            out_free_i,
  output dpe_pkg::ctrl_t  ctrl_o
);

  dpe_pkg::state_e state_q, state_d;
  dpe_pkg::op_e    op_q, op_d;
  logic [1:0]      axis_q, axis_d;

  // State, opcode and axis registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpe_pkg::ST_IDLE;
      op_q    <= dpe_pkg::OP_HALF;
      axis_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      axis_q  <= axis_d;
    end
  end

  // Next state and strobes.
  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    axis_d          = axis_q;
    ctrl_o.ready    = 1'b0;
    ctrl_o.mul_en   = 1'b0;
    ctrl_o.add_en   = 1'b0;
    ctrl_o.load_out = 1'b0;
    ctrl_o.op       = op_q;
    ctrl_o.axis     = axis_q;
    unique case (state_q)
      dpe_pkg::ST_IDLE: begin
        ctrl_o.ready = 1'b1;
        if (in_valid_i) begin
          state_d = dpe_pkg::ST_MUL;
          op_d    = is_step_i ? dpe_pkg::OP_FORCE : dpe_pkg::OP_HALF;
          axis_d  = 2'd0;
        end
      end
      dpe_pkg::ST_MUL: begin
        ctrl_o.mul_en = 1'b1;
        state_d       = dpe_pkg::ST_ADD;
      end
      dpe_pkg::ST_ADD: begin
        ctrl_o.add_en = 1'b1;
        state_d       = dpe_pkg::ST_MUL;
        unique case (op_q)
          dpe_pkg::OP_FORCE: op_d = dpe_pkg::OP_DAMP;
          dpe_pkg::OP_DAMP:  op_d = dpe_pkg::OP_ACCEL;
          dpe_pkg::OP_ACCEL: op_d = dpe_pkg::OP_POS;
          dpe_pkg::OP_POS: begin
            // Last axis done: finish with the box half extent.
            if (axis_q == 2'(dpe_pkg::AXES - 1)) begin
              op_d   = dpe_pkg::OP_HALF;
              axis_d = 2'd0;
            end else begin
              op_d   = dpe_pkg::OP_FORCE;
              axis_d = axis_q + 2'd1;
            end
          end
          dpe_pkg::OP_HALF: state_d = dpe_pkg::ST_FIN;
          default:          state_d = dpe_pkg::ST_FIN;
        endcase
      end
      dpe_pkg::ST_FIN: begin
        if (out_free_i) begin
          ctrl_o.load_out = 1'b1;
          state_d         = dpe_pkg::ST_IDLE;
        end
      end
      default: state_d = dpe_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/damped_particle_euler_integrator_top.sv =====
// Non-step items (loads, force adds, clears, unused kinds) run the box half extent
// through the shared multiplier and then the output load; a step first runs twelve
// operations through the one shared multiplier, then the half extent and the load.
// A new item waits until the last has loaded its result, which stalls on a full output
// register; the input is taken again while a result still waits there.
// Reset (rst_ni low, asynchronous): state vectors zero, registers to defaults.
module damped_particle_euler_integrator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // vec_x, vec_y, vec_z
  input  logic [2:0]   s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, box_min_x, box_min_y, box_min_z,
  // box_max_x, box_max_y, box_max_z
  output logic [383:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [30:0]        inv_mass_q;
  logic [30:0]        radius_q;
  logic [16:0]        damping_q;
  logic [16:0]        time_step_q;
  logic               explicit_q;

  logic signed [31:0] pos_q [dpe_pkg::AXES];
  logic signed [31:0] vel_q [dpe_pkg::AXES];
  logic signed [31:0] acc_q [dpe_pkg::AXES];
  logic signed [31:0] frc_q [dpe_pkg::AXES];
  logic signed [31:0] tmp_q;
  logic signed [31:0] nv_q;
  logic signed [32:0] half_q;

  logic signed [31:0] vin [dpe_pkg::AXES];
  logic               in_acc;
  logic               out_free;
  logic               out_valid_q;
  logic [383:0]       out_data_q;
  logic [383:0]       out_data_d;

  dpe_pkg::ctrl_t     ctrl;
  dpe_pkg::mac_req_t  mac_req;
  logic signed [31:0] mac_addend;
  logic signed [63:0] mac_rounded;
  logic signed [31:0] mac_sum;
  logic [1:0]         ax;

  assign ax          = ctrl.axis;
  assign cfg_ready_o = 1'b1;

  // Unpack the input beat.
  assign vin[0] = s_axis_tdata[31:0];
  assign vin[1] = s_axis_tdata[63:32];
  assign vin[2] = s_axis_tdata[95:64];

  assign s_axis_tready = ctrl.ready;
  assign in_acc        = s_axis_tvalid & ctrl.ready;
  assign out_free      = !out_valid_q || m_axis_tready;

  dpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .is_step_i  (s_axis_tuser == dpe_pkg::KIND_STEP),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // Operand selection for the shared unit.
  always_comb begin
    mac_req.a     = 33'(vel_q[ax]);
    mac_req.k     = $signed({15'd0, damping_q});
    mac_req.shift = dpe_pkg::SHIFT_DAMP;
    mac_addend    = 32'sd0;
    unique case (ctrl.op)
      dpe_pkg::OP_FORCE: begin
        mac_req.a     = 33'(frc_q[ax]);
        mac_req.k     = $signed({1'b0, inv_mass_q});
        mac_req.shift = dpe_pkg::SHIFT_FRAC;
        mac_addend    = acc_q[ax];
      end
      dpe_pkg::OP_DAMP: begin
        mac_req.a     = 33'(vel_q[ax]);
        mac_req.k     = $signed({15'd0, damping_q});
        mac_req.shift = dpe_pkg::SHIFT_DAMP;
      end
      dpe_pkg::OP_ACCEL: begin
        mac_req.a     = 33'(acc_q[ax]);
        mac_req.k     = $signed({15'd0, time_step_q});
        mac_req.shift = dpe_pkg::SHIFT_FRAC;
        mac_addend    = tmp_q;
      end
      dpe_pkg::OP_POS: begin
        // Explicit order moves with the old velocity, otherwise the new one.
        mac_req.a     = explicit_q ? 33'(vel_q[ax]) : 33'(nv_q);
        mac_req.k     = $signed({15'd0, time_step_q});
        mac_req.shift = dpe_pkg::SHIFT_FRAC;
        mac_addend    = pos_q[ax];
      end
      dpe_pkg::OP_HALF: begin
        mac_req.a     = $signed({2'b00, radius_q});
        mac_req.k     = dpe_pkg::SQRT3_FIXED;
        mac_req.shift = dpe_pkg::SHIFT_SQRT3;
      end
      default: mac_addend = 32'sd0;
    endcase
  end

  dpe_mac u_mac (
    .clk_i     (clk_i),
    .mul_en_i  (ctrl.mul_en),
    .req_i     (mac_req),
    .addend_i  (mac_addend),
    .rounded_o (mac_rounded),
    .sum_o     (mac_sum)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q  <= dpe_pkg::INV_MASS_RST;
      radius_q    <= dpe_pkg::RADIUS_RST;
      damping_q   <= dpe_pkg::DAMPING_RST;
      time_step_q <= dpe_pkg::TIME_STEP_RST;
      explicit_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dpe_pkg::CFG_INV_MASS:  inv_mass_q  <= cfg_data_i[30:0];
        dpe_pkg::CFG_RADIUS:    radius_q    <= cfg_data_i[30:0];
        dpe_pkg::CFG_DAMPING:   damping_q   <= cfg_data_i[16:0];
        dpe_pkg::CFG_TIME_STEP: time_step_q <= cfg_data_i[16:0];
        dpe_pkg::CFG_EXPLICIT:  explicit_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Particle state: direct updates on accept, shared-unit writebacks after.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dpe_pkg::AXES; i++) begin
        pos_q[i] <= 32'sd0;
        vel_q[i] <= 32'sd0;
        acc_q[i] <= 32'sd0;
        frc_q[i] <= 32'sd0;
      end
      tmp_q  <= 32'sd0;
      nv_q   <= 32'sd0;
      half_q <= 33'sd0;
    end else if (in_acc) begin
      case (s_axis_tuser)
        dpe_pkg::KIND_FORCE: begin
          for (int i = 0; i < dpe_pkg::AXES; i++) begin
            frc_q[i] <= dpe_pkg::sat32(64'(frc_q[i]) + 64'(vin[i]));
          end
        end
        dpe_pkg::KIND_CLEAR: begin
          for (int i = 0; i < dpe_pkg::AXES; i++) begin
            acc_q[i] <= 32'sd0;
            frc_q[i] <= 32'sd0;
          end
        end
        dpe_pkg::KIND_SET_POS: begin
          for (int i = 0; i < dpe_pkg::AXES; i++) pos_q[i] <= vin[i];
        end
        dpe_pkg::KIND_SET_VEL: begin
          for (int i = 0; i < dpe_pkg::AXES; i++) vel_q[i] <= vin[i];
        end
        dpe_pkg::KIND_SET_ACC: begin
          for (int i = 0; i < dpe_pkg::AXES; i++) acc_q[i] <= vin[i];
        end
        default: ;
      endcase
    end else if (ctrl.add_en) begin
      unique case (ctrl.op)
        dpe_pkg::OP_FORCE: acc_q[ax] <= mac_sum;
        dpe_pkg::OP_DAMP:  tmp_q     <= mac_sum;
        dpe_pkg::OP_ACCEL: nv_q      <= mac_sum;
        dpe_pkg::OP_POS: begin
          pos_q[ax] <= mac_sum;
          vel_q[ax] <= nv_q;
        end
        dpe_pkg::OP_HALF:  half_q    <= mac_rounded[32:0];
        default: ;
      endcase
    end
  end

  // Result beat: position, velocity and the saturated bounding box.
  always_comb begin
    for (int i = 0; i < dpe_pkg::AXES; i++) begin
      out_data_d[32*i +: 32]      = pos_q[i];
      out_data_d[96 + 32*i +: 32] = vel_q[i];
      out_data_d[192 + 32*i +: 32] = dpe_pkg::sat32(64'(pos_q[i]) - 64'(half_q));
      out_data_d[288 + 32*i +: 32] = dpe_pkg::sat32(64'(pos_q[i]) + 64'(half_q));
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== src/dpe_checker.sv =====
// Port-level checker for the damped particle Euler integrator, bound to the top.
// Depends only on the top level's port list.
module dpe_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [383:0] m_axis_tdata
);

  // An accepted beat keeps the input closed while its item is busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("input reopened before the item finished");

  // A new result appears only at the end of an item's work.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a finished item");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

endmodule

bind damped_particle_euler_integrator_top dpe_checker u_dpe_checker (.*);

// ===== test/particle_state_checker.sv =====
// Checker for the damped particle Euler integrator: follows the input, result
// and register channels, predicts every result beat and compares it field by field.
// Depends on dpe_pkg for item kinds, register indexes and fixed-point formats.
`timescale 1ns / 100ps

module particle_state_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // vec_x, vec_y, vec_z
  input  logic [2:0]   s_axis_tuser,   // kind
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, box_min_x, box_min_y, box_min_z,
  // box_max_x, box_max_y, box_max_z
  input  logic [383:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam int REPORT_LIMIT = 10;
  localparam int NUM_FIELDS   = 12;

  string field_label [NUM_FIELDS] = '{
    "pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
    "box_min_x", "box_min_y", "box_min_z", "box_max_x", "box_max_y", "box_max_z"
  };

  // Shadow copy of the register file.
  logic [30:0] inv_mass_q;
  logic [30:0] radius_q;
  logic [16:0] damping_q;
  logic [16:0] dt_q;
  logic        explicit_q;

  // Shadow copy of the particle.
  int pos_q   [dpe_pkg::AXES];
  int vel_q   [dpe_pkg::AXES];
  int acc_q   [dpe_pkg::AXES];
  int force_q [dpe_pkg::AXES];

  // Predicted result beats, oldest first.
  logic [383:0] predicted_beats [$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Add half an LSB, then floor by the arithmetic shift.
  function automatic longint round_shift(input longint p, input int s);
    return (p + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint scale_term(input longint a, input longint k, input int s);
    return clamp32(round_shift(a * k, s));
  endfunction

  function automatic void reset_particle();
    inv_mass_q = dpe_pkg::INV_MASS_RST;
    radius_q   = dpe_pkg::RADIUS_RST;
    damping_q  = dpe_pkg::DAMPING_RST;
    dt_q       = dpe_pkg::TIME_STEP_RST;
    explicit_q = 1'b0;
    for (int i = 0; i < dpe_pkg::AXES; i++) begin
      pos_q[i]   = 0;
      vel_q[i]   = 0;
      acc_q[i]   = 0;
      force_q[i] = 0;
    end
  endfunction

  // Indexes past the register list are dropped.
  function automatic void write_register(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      dpe_pkg::CFG_INV_MASS:  inv_mass_q = data[30:0];
      dpe_pkg::CFG_RADIUS:    radius_q   = data[30:0];
      dpe_pkg::CFG_DAMPING:   damping_q  = data[16:0];
      dpe_pkg::CFG_TIME_STEP: dt_q       = data[16:0];
      dpe_pkg::CFG_EXPLICIT:  explicit_q = data[0];
      default: ;
    endcase
  endfunction

  // One integration step; the force accumulator is left as it is.
  function automatic void integrate_step();
    longint old_v;
    longint new_v;
    longint move_v;
    for (int i = 0; i < dpe_pkg::AXES; i++) begin
      acc_q[i] = int'(clamp32(longint'(acc_q[i]) +
                              scale_term(force_q[i], inv_mass_q, dpe_pkg::FRAC_BITS)));
    end
    for (int i = 0; i < dpe_pkg::AXES; i++) begin
      old_v    = vel_q[i];
      new_v    = clamp32(scale_term(old_v, damping_q, dpe_pkg::DAMP_BITS) +
                         scale_term(acc_q[i], dt_q, dpe_pkg::FRAC_BITS));
      move_v   = explicit_q ? old_v : new_v;
      pos_q[i] = int'(clamp32(longint'(pos_q[i]) +
                              scale_term(move_v, dt_q, dpe_pkg::FRAC_BITS)));
      vel_q[i] = int'(new_v);
    end
  endfunction

  // Apply one item to the shadow particle and build the result it reports.
  function automatic logic [383:0] apply_item(input logic [2:0] kind, input logic [95:0] vec);
    int           v [dpe_pkg::AXES];
    longint       half;
    logic [383:0] res;
    for (int i = 0; i < dpe_pkg::AXES; i++) v[i] = vec[32*i +: 32];
    case (kind)
      dpe_pkg::KIND_FORCE: begin
        for (int i = 0; i < dpe_pkg::AXES; i++)
          force_q[i] = int'(clamp32(longint'(force_q[i]) + v[i]));
      end
      dpe_pkg::KIND_STEP: begin
        integrate_step();
      end
      dpe_pkg::KIND_CLEAR: begin
        for (int i = 0; i < dpe_pkg::AXES; i++) begin
          acc_q[i]   = 0;
          force_q[i] = 0;
        end
      end
      dpe_pkg::KIND_SET_POS: begin
        for (int i = 0; i < dpe_pkg::AXES; i++) pos_q[i] = v[i];
      end
      dpe_pkg::KIND_SET_VEL: begin
        for (int i = 0; i < dpe_pkg::AXES; i++) vel_q[i] = v[i];
      end
      dpe_pkg::KIND_SET_ACC: begin
        for (int i = 0; i < dpe_pkg::AXES; i++) acc_q[i] = v[i];
      end
      default: ;
    endcase
    // The half extent is kept wide; only the box edges are clamped.
    half = round_shift(longint'(radius_q) * longint'(dpe_pkg::SQRT3_FIXED),
                       dpe_pkg::SQRT3_BITS);
    for (int i = 0; i < dpe_pkg::AXES; i++) begin
      res[32*i +: 32]       = pos_q[i];
      res[32*(3+i) +: 32]   = vel_q[i];
      res[32*(6+i) +: 32]   = 32'(clamp32(longint'(pos_q[i]) - half));
      res[32*(9+i) +: 32]   = 32'(clamp32(longint'(pos_q[i]) + half));
    end
    return res;
  endfunction

  // Retire result beats first, then take register writes and new items.
  always @(posedge clk_i) begin : watch
    logic [383:0] want;
    if (!rst_ni) begin
      reset_particle();
      predicted_beats.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_beats.size() == 0) begin
          if (fail_count_o < REPORT_LIMIT)
            $display("%0t: result beat with nothing expected: %h", $time, m_axis_tdata);
          fail_count_o++;
        end else begin
          want = predicted_beats.pop_front();
          for (int f = 0; f < NUM_FIELDS; f++) begin
            if (want[32*f +: 32] !== m_axis_tdata[32*f +: 32]) begin
              if (fail_count_o < REPORT_LIMIT)
                $display("%0t: %s expected %h got %h", $time, field_label[f],
                         want[32*f +: 32], m_axis_tdata[32*f +: 32]);
              fail_count_o++;
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) write_register(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready)
        predicted_beats.push_back(apply_item(s_axis_tuser, s_axis_tdata));
    end
    pending_o <= predicted_beats.size();
  end

endmodule

// ===== test/tb_damped_particle_euler_integrator_top.sv =====
// Testbench top for the damped particle Euler integrator: clock, reset, item
// and register stimulus, receiver stalls and the verdict.
// Depends on dpe_pkg, the block's top level and particle_state_checker.
`timescale 1ns / 100ps

module tb_damped_particle_euler_integrator_top;

  // Kinds the block leaves without effect.
  localparam logic [2:0] KIND_SPARE_A    = 3'd6;
  localparam logic [2:0] KIND_SPARE_B    = 3'd7;
  // Register indexes past the end of the list.
  localparam logic [2:0] CFG_UNUSED_LO   = 3'd5;
  localparam logic [2:0] CFG_UNUSED_HI   = 3'd7;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int TAIL_CYCLES     = 40;
  localparam int TIMEOUT_NS      = 4_000_000;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata  = '0;
  logic [2:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [383:0] m_axis_tdata;
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i   = '0;
  logic [31:0]  cfg_data_i    = '0;

  int   fail_count;
  int   pending;
  int   burst_left = 0;
  int   kind_seen [8];
  int   settings_used = 0;
  logic hold_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  damped_particle_euler_integrator_top DUT (.*);

  particle_state_checker u_checker (
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .*
  );

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Send one item beat; a new burst starts after a random gap.
  task automatic send_item(input logic [2:0] kind, input logic [31:0] vx,
                           input logic [31:0] vy, input logic [31:0] vz);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {vz, vy, vx};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    kind_seen[kind]++;
  endtask

  // Stop offering items and wait until every predicted beat has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic cfg_beat(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write the whole register file; bits above each field carry noise.
  task automatic program_regs(input logic [30:0] inv_mass, input logic [30:0] radius,
                              input logic [16:0] damping, input logic [16:0] dt,
                              input logic explicit_order, input bit stray);
    logic [31:0] word;
    word = $urandom; word[30:0] = inv_mass;  cfg_beat(dpe_pkg::CFG_INV_MASS, word);
    word = $urandom; word[30:0] = radius;    cfg_beat(dpe_pkg::CFG_RADIUS, word);
    word = $urandom; word[16:0] = damping;   cfg_beat(dpe_pkg::CFG_DAMPING, word);
    word = $urandom; word[16:0] = dt;        cfg_beat(dpe_pkg::CFG_TIME_STEP, word);
    word = $urandom; word[0] = explicit_order; cfg_beat(dpe_pkg::CFG_EXPLICIT, word);
    if (stray) begin
      cfg_beat(CFG_UNUSED_LO, $urandom);
      cfg_beat(CFG_UNUSED_HI, $urandom);
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [30:0] pick_wide_reg();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 31'h7fffffff;
      2:       return 31'($urandom_range(1 << 12, 1 << 18));
      3:       return 31'($urandom);
      default: return 31'd65536;
    endcase
  endfunction

  task automatic random_regs();
    logic [16:0] damping;
    logic [16:0] dt;
    case ($urandom_range(0, 4))
      0:       damping = '0;
      1:       damping = 17'd65536;
      2:       damping = 17'h1ffff;
      3:       damping = 17'($urandom);
      default: damping = 17'($urandom_range(60000, 65536));
    endcase
    case ($urandom_range(0, 5))
      0:       dt = '0;
      1:       dt = 17'd65536;
      2:       dt = 17'h1ffff;
      3:       dt = 17'($urandom_range(1, 4096));
      default: dt = 17'($urandom_range(256, 2048));
    endcase
    program_regs(pick_wide_reg(), pick_wide_reg(), damping, dt, 1'($urandom),
                 1'($urandom_range(0, 1)));
  endtask

  // Mostly modest values so the particle moves without pinning at the rails.
  function automatic logic [31:0] rand_comp();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
    if (pick < 9) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'hffffffff;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [2:0] rand_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return dpe_pkg::KIND_FORCE;
    if (r < 60) return dpe_pkg::KIND_STEP;
    if (r < 68) return dpe_pkg::KIND_CLEAR;
    if (r < 76) return dpe_pkg::KIND_SET_POS;
    if (r < 84) return dpe_pkg::KIND_SET_VEL;
    if (r < 92) return dpe_pkg::KIND_SET_ACC;
    if (r < 96) return KIND_SPARE_A;
    return KIND_SPARE_B;
  endfunction

  // Receiver: changes its stall pattern now and then, and holds off once on request.
  initial begin : receiver
    int mode;
    int left;
    bit hold_done;
    left      = 0;
    mode      = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done     = 1'b1;
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (left % 3 == 0);
        endcase
      end
    end
  end

  // Main sequence: directed corners, then random phases under random settings.
  initial begin : stimulus
    logic [2:0] kind;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: rail values, box clamping, force persistence, unused kinds.
    send_item(dpe_pkg::KIND_STEP,    32'h0,        32'h0,        32'h0);
    send_item(dpe_pkg::KIND_SET_POS, 32'h7fffffff, 32'h80000000, 32'h0);
    send_item(dpe_pkg::KIND_SET_VEL, 32'h7fffffff, 32'h80000000, 32'h00010000);
    send_item(dpe_pkg::KIND_SET_ACC, 32'h7fffffff, 32'h80000000, 32'hfffe0000);
    send_item(dpe_pkg::KIND_STEP,    32'h0,        32'h0,        32'h0);
    send_item(dpe_pkg::KIND_FORCE,   32'h7fffffff, 32'h80000000, 32'h12345678);
    send_item(dpe_pkg::KIND_FORCE,   32'h7fffffff, 32'h80000000, 32'h12345678);
    send_item(dpe_pkg::KIND_STEP,    32'h0,        32'h0,        32'h0);
    send_item(dpe_pkg::KIND_STEP,    32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_item(dpe_pkg::KIND_CLEAR,   32'hffffffff, 32'h0,        32'h0);
    send_item(dpe_pkg::KIND_STEP,    32'h0,        32'h0,        32'h0);
    send_item(KIND_SPARE_A,          $urandom,     $urandom,     $urandom);
    send_item(KIND_SPARE_B,          32'hffffffff, 32'h80000000, 32'h7fffffff);
    send_item(dpe_pkg::KIND_SET_POS, 32'hfff80000, 32'h00030000, 32'hffff8000);
    send_item(dpe_pkg::KIND_SET_VEL, 32'h00020000, 32'hfffe0000, 32'h00008000);
    send_item(dpe_pkg::KIND_FORCE,   32'h00010000, 32'hffff0000, 32'h00040000);
    send_item(dpe_pkg::KIND_STEP,    32'h0,        32'h0,        32'h0);
    drain_results();

    // Largest in-range settings, explicit order.
    program_regs(31'h7fffffff, 31'h7fffffff, 17'd65536, 17'd65536, 1'b1, 1'b1);
    send_item(dpe_pkg::KIND_SET_VEL, 32'h00010000, 32'hffff0000, 32'h0);
    send_item(dpe_pkg::KIND_FORCE,   32'h00010000, 32'h00000001, 32'hffffffff);
    send_item(dpe_pkg::KIND_STEP,    32'h0,        32'h0,        32'h0);
    send_item(dpe_pkg::KIND_STEP,    32'h0,        32'h0,        32'h0);
    drain_results();

    // Immovable, point-sized particle; damping and dt past their range.
    program_regs(31'h0, 31'h0, 17'h1ffff, 17'h1ffff, 1'b0, 1'b1);
    send_item(dpe_pkg::KIND_SET_VEL, 32'h40000000, 32'hc0000000, 32'h00010000);
    send_item(dpe_pkg::KIND_FORCE,   32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_item(dpe_pkg::KIND_STEP,    32'h0,        32'h0,        32'h0);
    send_item(dpe_pkg::KIND_STEP,    32'h0,        32'h0,        32'h0);
    drain_results();

    // Random phases; one of them starts with a long receiver hold-off.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_regs();
      if (phase == 3) hold_req <= 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = rand_kind();
        send_item(kind, rand_comp(), rand_comp(), rand_comp());
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d steps, %0d force adds, %0d clears, %0d loads, %0d unused kinds",
             kind_seen[dpe_pkg::KIND_STEP], kind_seen[dpe_pkg::KIND_FORCE],
             kind_seen[dpe_pkg::KIND_CLEAR],
             kind_seen[dpe_pkg::KIND_SET_POS] + kind_seen[dpe_pkg::KIND_SET_VEL] +
             kind_seen[dpe_pkg::KIND_SET_ACC],
             kind_seen[KIND_SPARE_A] + kind_seen[KIND_SPARE_B]);
    $display("over %0d register settings, with one %0d-cycle output hold-off.",
             settings_used + 1, HOLD_OFF_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dpe_pkg.sv
src/dpe_mac.sv
src/dpe_ctrl.sv
src/damped_particle_euler_integrator_top.sv
src/dpe_checker.sv
test/particle_state_checker.sv
test/tb_damped_particle_euler_integrator_top.sv
